### hdl/ip_forward_filter_with_arp_learning_macros.svh
// Assertion macros used by the top-level file to check its own logic.
`ifndef IP_FORWARD_FILTER_WITH_ARP_LEARNING_MACROS_SVH
`define IP_FORWARD_FILTER_WITH_ARP_LEARNING_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPFF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPFF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/ipff_pkg.sv
package ipff_pkg;

   localparam int ROUTE_ENTRIES_DEFAULT = 16;
   localparam int ARP_ENTRIES_DEFAULT   = 32;

   localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
   localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;

   localparam logic REQ_ROUTE_WRITE = 1'b0;
   localparam logic REQ_FRAME       = 1'b1;

   localparam int REQ_DATA_W = 296;
   localparam int RSP_DATA_W = 88;

   typedef enum logic [3:0] {
      ST_ROUTE        = 4'd0,
      ST_TYPE_IGN     = 4'd1,
      ST_ARP_IGN      = 4'd2,
      ST_ARP_LEARN    = 4'd3,
      ST_ARP_FULL     = 4'd4,
      ST_FORWARD      = 4'd5,
      ST_SRC_NONLOCAL = 4'd6,
      ST_DST_LOCAL    = 4'd7,
      ST_MAC_MISMATCH = 4'd8
   } status_type;

   typedef struct packed {
      logic       load;
      logic       scan;
      logic       route_wr;
      logic       arp_wr;
      logic       rsp_load;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic needs_scan;
      logic is_route;
      logic is_arp;
      logic is_ipv4;
      logic tmac_zero;
      logic scan_last;
      logic src_hit;
      logic dst_hit;
      logic arp_hit;
      logic mac_eq;
      logic free_found;
      logic rsp_busy;
   } stat_type;

endpackage

### hdl/ip_forward_filter_with_arp_learning.sv
// IPv4 forward filter with ARP learning. Each request transaction is either a
// route-table write (tuser 0) or a parsed frame header (tuser 1), and each
// produces exactly one response transaction carrying a status code. ARP frames
// teach the block IP-to-MAC pairs; IPv4 frames are forwarded only when the
// source lies in a known route (longest prefix, earlier slot wins a tie), the
// destination does not, and, if own_ip is known to ARP, the frame's destination
// MAC equals the learned one. One transaction is worked at a time. A route
// write or a frame that needs no table lookup goes from idle straight to the
// decision state; an IPv4 frame, or an ARP frame with a nonzero target MAC,
// first runs a scan of max(ROUTE_ENTRIES, ARP_ENTRIES) slots that reads one
// route slot and one ARP slot per cycle from the table memories. A new request is
// accepted as soon as the block is back in idle, even while the previous
// response still waits to be taken. Valid marks of both tables clear at reset,
// so no clearing pass is needed.
`include "ip_forward_filter_with_arp_learning_macros.svh"

module ip_forward_filter_with_arp_learning #(
   parameter int ROUTE_ENTRIES = ipff_pkg::ROUTE_ENTRIES_DEFAULT,
   parameter int ARP_ENTRIES   = ipff_pkg::ARP_ENTRIES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration: own_ip, written whenever csr_we is high.
   input  logic                            csr_we,
   input  logic [31:0]                     csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // route_index[3:0], route_valid[4], route_net[36:5], route_mask[68:37],
   // ether_type[84:69], src_ip[116:85], dst_ip[148:117], frame_dst_mac[196:149],
   // arp_sender_mac[244:197], arp_target_mac[292:245], zero pad [295:293]
   input  logic [ipff_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type[0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[3:0], learned_ip[35:4], learned_mac[83:36], src_route[87:84]
   output logic [ipff_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic [31:0]        own_ip_ff;
   ipff_pkg::cmd_type  cmd;
   ipff_pkg::stat_type stat;

   // The user must change the own address only while the block is idle; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff <= '0;
      end else if (csr_we) begin
         own_ip_ff <= csr_wdata;
      end
   end

   // Sequencer: idle, table scan, decision and response load.
   ipff_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Tables, scan comparators and output register.
   ipff_datapath #(
      .ROUTE_ENTRIES (ROUTE_ENTRIES),
      .ARP_ENTRIES   (ARP_ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .own_ip     (own_ip_ff),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // After a request is taken the block is busy in the next cycle.
   `IPFF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted while busy")
   // Learned pair is reported only with a learn status.
   `IPFF_ASSERT_SAME(a_learn_fields, clock, reset, rsp_tvalid && (rsp_tdata[3:0] != ipff_pkg::ST_ARP_LEARN), (rsp_tdata[83:4] == 80'd0), "learned fields nonzero")
   // Source route is reported only with a forward status.
   `IPFF_ASSERT_SAME(a_route_field, clock, reset, rsp_tvalid && (rsp_tdata[3:0] != ipff_pkg::ST_FORWARD), (rsp_tdata[87:84] == 4'd0), "src_route nonzero")

endmodule

### hdl/ipff_ctrl.sv
module ipff_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  ipff_pkg::stat_type stat,
   output ipff_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_DECIDE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   ipff_pkg::status_type verdict;
   logic arp_store;

   assign req_tready = (state_ff == S_IDLE);

   // Decision from request type and any scan; checks run in the filter's order.
   always_comb begin
      arp_store = 1'b0;
      if (stat.is_route) begin
         verdict = ipff_pkg::ST_ROUTE;
      end else if (stat.is_arp) begin
         if (stat.tmac_zero || (stat.arp_hit && stat.mac_eq)) begin
            verdict = ipff_pkg::ST_ARP_IGN;
         end else if (!stat.arp_hit && !stat.free_found) begin
            verdict = ipff_pkg::ST_ARP_FULL;
         end else begin
            verdict   = ipff_pkg::ST_ARP_LEARN;
            arp_store = 1'b1;
         end
      end else if (stat.is_ipv4) begin
         if (!stat.src_hit) begin
            verdict = ipff_pkg::ST_SRC_NONLOCAL;
         end else if (stat.dst_hit) begin
            verdict = ipff_pkg::ST_DST_LOCAL;
         end else if (stat.arp_hit && !stat.mac_eq) begin
            verdict = ipff_pkg::ST_MAC_MISMATCH;
         end else begin
            verdict = ipff_pkg::ST_FORWARD;
         end
      end else begin
         verdict = ipff_pkg::ST_TYPE_IGN;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.status = verdict;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = stat.needs_scan ? S_SCAN : S_DECIDE;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               cmd.route_wr = stat.is_route;
               cmd.arp_wr   = arp_store;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/ipff_datapath.sv
module ipff_datapath #(
   parameter int ROUTE_ENTRIES = ipff_pkg::ROUTE_ENTRIES_DEFAULT,
   parameter int ARP_ENTRIES   = ipff_pkg::ARP_ENTRIES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ipff_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   input  logic [31:0]                     own_ip,
   input  ipff_pkg::cmd_type               cmd,
   output ipff_pkg::stat_type              stat,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ipff_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int RW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
   localparam int AW = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1;
   localparam int SCAN_LEN = (ROUTE_ENTRIES > ARP_ENTRIES) ? ROUTE_ENTRIES : ARP_ENTRIES;
   localparam int CW = $clog2(SCAN_LEN + 1);

   // Captured request.
   logic        type_ff;
   logic [3:0]  ridx_ff;
   logic        rvalid_ff;
   logic [31:0] rnet_ff, rmask_ff, src_ff, dst_ff;
   logic [15:0] ftype_ff;
   logic [47:0] fdmac_ff, smac_ff, tmac_ff;

   // Tables.
   logic [31:0] route_net_mem  [ROUTE_ENTRIES];
   logic [31:0] route_mask_mem [ROUTE_ENTRIES];
   logic [31:0] arp_key_mem    [ARP_ENTRIES];
   logic [47:0] arp_mac_mem    [ARP_ENTRIES];
   logic [ROUTE_ENTRIES-1:0] route_valid_ff;
   logic [ARP_ENTRIES-1:0]   arp_valid_ff;

   // Scan pipeline.
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] idx_d_ff;
   logic          rt_v_ff, ar_v_ff;
   logic [31:0]   rt_net_rd_ff, rt_mask_rd_ff, ar_key_rd_ff;
   logic [47:0]   ar_mac_rd_ff;
   logic          issue;

   // Lookup results.
   logic          src_hit_ff, dst_hit_ff, arp_hit_ff, free_ff;
   logic [RW-1:0] src_best_ff;
   logic [31:0]   src_mask_ff;
   logic [AW-1:0] arp_slot_ff, free_slot_ff;
   logic [47:0]   arp_mac_ff;

   logic          rsp_valid_ff;
   ipff_pkg::status_type rsp_status_ff;
   logic [31:0]   rsp_ip_ff;
   logic [47:0]   rsp_mac_ff;
   logic [3:0]    rsp_route_ff;

   logic          is_frame, is_arp, is_ipv4;
   logic          in_frame, in_arp, in_ipv4, in_tmac_zero;
   logic [RW-1:0] ridx_rd;
   logic [AW-1:0] aidx_rd;
   logic          rmatch_src, rmatch_dst, amatch, afree;
   logic [31:0]   arp_lookup_ip;
   logic [AW-1:0] arp_wr_addr;
   logic [RW-1:0] route_wr_addr;

   assign in_frame     = (req_tuser == ipff_pkg::REQ_FRAME);
   assign in_arp       = in_frame && (req_tdata[84:69] == ipff_pkg::ETH_TYPE_ARP);
   assign in_ipv4      = in_frame && (req_tdata[84:69] == ipff_pkg::ETH_TYPE_IPV4);
   assign in_tmac_zero = (req_tdata[292:245] == 48'd0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff   <= req_tuser;
         ridx_ff   <= req_tdata[3:0];
         rvalid_ff <= req_tdata[4];
         rnet_ff   <= req_tdata[36:5];
         rmask_ff  <= req_tdata[68:37];
         ftype_ff  <= req_tdata[84:69];
         src_ff    <= req_tdata[116:85];
         dst_ff    <= req_tdata[148:117];
         fdmac_ff  <= req_tdata[196:149];
         smac_ff   <= req_tdata[244:197];
         tmac_ff   <= req_tdata[292:245];
      end
   end

   assign is_frame = (type_ff == ipff_pkg::REQ_FRAME);
   assign is_arp   = is_frame && (ftype_ff == ipff_pkg::ETH_TYPE_ARP);
   assign is_ipv4  = is_frame && (ftype_ff == ipff_pkg::ETH_TYPE_IPV4);

   assign arp_lookup_ip = is_arp ? src_ff : own_ip;

   // Scan counter walks both tables; read data is registered and returns in the next cycle.
   assign issue = cmd.scan && (cnt_ff != CW'(SCAN_LEN));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         rt_v_ff <= 1'b0;
         ar_v_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            cnt_ff <= '0;
         end else if (issue) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
         rt_v_ff <= issue && (int'(cnt_ff) < ROUTE_ENTRIES);
         ar_v_ff <= issue && (int'(cnt_ff) < ARP_ENTRIES);
      end
   end

   always_ff @(posedge clock) begin
      idx_d_ff <= cnt_ff;
      if (issue) begin
         rt_net_rd_ff  <= route_net_mem[cnt_ff[RW-1:0]];
         rt_mask_rd_ff <= route_mask_mem[cnt_ff[RW-1:0]];
         ar_key_rd_ff  <= arp_key_mem[cnt_ff[AW-1:0]];
         ar_mac_rd_ff  <= arp_mac_mem[cnt_ff[AW-1:0]];
      end
   end

   assign ridx_rd = idx_d_ff[RW-1:0];
   assign aidx_rd = idx_d_ff[AW-1:0];

   assign rmatch_src = rt_v_ff && route_valid_ff[ridx_rd] &&
                       ((src_ff & rt_mask_rd_ff) == rt_net_rd_ff);
   assign rmatch_dst = rt_v_ff && route_valid_ff[ridx_rd] &&
                       ((dst_ff & rt_mask_rd_ff) == rt_net_rd_ff);
   assign amatch = ar_v_ff && arp_valid_ff[aidx_rd] && (ar_key_rd_ff == arp_lookup_ip);
   assign afree  = ar_v_ff && !arp_valid_ff[aidx_rd];

   // Longest prefix keeps the earlier entry on an equal mask; ARP keeps the first hit.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         src_hit_ff <= 1'b0;
         dst_hit_ff <= 1'b0;
         arp_hit_ff <= 1'b0;
         free_ff    <= 1'b0;
      end else begin
         if (rmatch_src && (!src_hit_ff || (rt_mask_rd_ff > src_mask_ff))) begin
            src_hit_ff  <= 1'b1;
            src_best_ff <= ridx_rd;
            src_mask_ff <= rt_mask_rd_ff;
         end
         if (rmatch_dst) begin
            dst_hit_ff <= 1'b1;
         end
         if (amatch && !arp_hit_ff) begin
            arp_hit_ff  <= 1'b1;
            arp_slot_ff <= aidx_rd;
            arp_mac_ff  <= ar_mac_rd_ff;
         end
         if (afree && !free_ff) begin
            free_ff      <= 1'b1;
            free_slot_ff <= aidx_rd;
         end
      end
   end

   assign route_wr_addr = RW'(ridx_ff);
   assign arp_wr_addr   = arp_hit_ff ? arp_slot_ff : free_slot_ff;

   always_ff @(posedge clock) begin
      if (cmd.route_wr && ({5'd0, ridx_ff} < 9'(ROUTE_ENTRIES))) begin
         route_net_mem[route_wr_addr]  <= rnet_ff;
         route_mask_mem[route_wr_addr] <= rmask_ff;
      end
      if (cmd.arp_wr) begin
         arp_key_mem[arp_wr_addr] <= src_ff;
         arp_mac_mem[arp_wr_addr] <= smac_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         route_valid_ff <= '0;
         arp_valid_ff   <= '0;
      end else begin
         if (cmd.route_wr && ({5'd0, ridx_ff} < 9'(ROUTE_ENTRIES))) begin
            route_valid_ff[route_wr_addr] <= rvalid_ff;
         end
         if (cmd.arp_wr) begin
            arp_valid_ff[arp_wr_addr] <= 1'b1;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.status;
         rsp_ip_ff     <= (cmd.status == ipff_pkg::ST_ARP_LEARN) ? src_ff : 32'd0;
         rsp_mac_ff    <= (cmd.status == ipff_pkg::ST_ARP_LEARN) ? smac_ff : 48'd0;
         rsp_route_ff  <= (cmd.status == ipff_pkg::ST_FORWARD) ? 4'(src_best_ff) : 4'd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_route_ff, rsp_mac_ff, rsp_ip_ff, rsp_status_ff};

   always_comb begin
      stat.needs_scan = in_ipv4 || (in_arp && !in_tmac_zero);
      stat.is_route   = (type_ff == ipff_pkg::REQ_ROUTE_WRITE);
      stat.is_arp     = is_arp;
      stat.is_ipv4    = is_ipv4;
      stat.tmac_zero  = (tmac_ff == 48'd0);
      stat.scan_last  = (cnt_ff == CW'(SCAN_LEN));
      stat.src_hit    = src_hit_ff;
      stat.dst_hit    = dst_hit_ff;
      stat.arp_hit    = arp_hit_ff;
      stat.mac_eq     = (arp_mac_ff == (is_arp ? smac_ff : fdmac_ff));
      stat.free_found = free_ff;
      stat.rsp_busy   = rsp_valid_ff && !rsp_tready;
   end

endmodule
